FILE: sv/lpid_pkg.sv
// Shared types, constants and helpers for the leaky PID core.
// No dependencies; used by every lpid_* module and the top level.
package lpid_pkg;

  localparam int DATA_W = 32;
  localparam int ACC_W  = 48;
  localparam int DEC_W  = 16;
  localparam int VAL_W  = 66;   // wide enough for every sum in the datapath
  localparam int RES_W  = 65;   // signed result of the multiply / divide units
  localparam int IDX_W  = 4;

  localparam int IN_W  = 96;
  localparam int OUT_W = 104;

  localparam logic [16:0] DECAY_ONE = 17'h10000;

  typedef logic signed [VAL_W-1:0] sval_t;
  typedef logic [3:0] op_t;
  typedef logic [1:0] unit_t;

  // config register indexes
  localparam logic [IDX_W-1:0] REG_KP   = 4'd0;
  localparam logic [IDX_W-1:0] REG_KI   = 4'd1;
  localparam logic [IDX_W-1:0] REG_KD   = 4'd2;
  localparam logic [IDX_W-1:0] REG_KFF  = 4'd3;
  localparam logic [IDX_W-1:0] REG_IDEC = 4'd4;
  localparam logic [IDX_W-1:0] REG_FDEC = 4'd5;
  localparam logic [IDX_W-1:0] REG_MODE = 4'd6;
  localparam logic [IDX_W-1:0] REG_EN   = 4'd7;

  // datapath operations
  localparam op_t OP_LOAD = 4'd0;   // capture beat, error
  localparam op_t OP_FK   = 4'd1;   // filter sum decay + error
  localparam op_t OP_FE   = 4'd2;   // filtered error
  localparam op_t OP_NOF  = 4'd3;   // filter bypass
  localparam op_t OP_DV   = 4'd4;   // derivative divide
  localparam op_t OP_DZ   = 4'd5;   // zero step
  localparam op_t OP_AK   = 4'd6;   // accumulator decay
  localparam op_t OP_AI   = 4'd7;   // accumulator add e*dt
  localparam op_t OP_IN   = 4'd8;   // normalize integral
  localparam op_t OP_SI   = 4'd9;   // ki term
  localparam op_t OP_SD   = 4'd10;  // kd term
  localparam op_t OP_PK   = 4'd11;  // kp product
  localparam op_t OP_PF   = 4'd12;  // feedforward
  localparam op_t OP_FIN  = 4'd13;  // results

  localparam unit_t UNIT_NONE = 2'd0;
  localparam unit_t UNIT_MUL  = 2'd1;
  localparam unit_t UNIT_DIV  = 2'd2;

  typedef struct packed {
    logic go;
    logic wb;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic filt_on;
    logic ff_on;
    logic dt_zero;
  } stat_t;

  function automatic unit_t unit_of(input op_t op);
    unit_t u;
    case (op)
      OP_FK, OP_FE, OP_AK, OP_AI, OP_SI, OP_SD, OP_PK, OP_PF: u = UNIT_MUL;
      OP_DV, OP_IN: u = UNIT_DIV;
      default: u = UNIT_NONE;
    endcase
    return u;
  endfunction

  function automatic sval_t clip(input sval_t v, input int w);
    sval_t hi, lo;
    hi = (sval_t'(1) <<< (w - 1)) - sval_t'(1);
    lo = -hi - sval_t'(1);
    if (v > hi) return hi;
    else if (v < lo) return lo;
    return v;
  endfunction

  function automatic logic ovf(input sval_t v, input int w);
    sval_t hi, lo;
    hi = (sval_t'(1) <<< (w - 1)) - sval_t'(1);
    lo = -hi - sval_t'(1);
    return (v > hi) || (v < lo);
  endfunction

endpackage

FILE: sv/lpid_mul.sv
// Signed fixed-point multiplier, (a*b)>>16 truncated toward zero.
// Two 24x32 partial products, formed one after the other; depends on lpid_pkg.
module lpid_mul
  import lpid_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    go,
  input  logic signed [ACC_W-1:0] a,
  input  logic signed [32:0]      b,
  output logic                    done,
  output logic signed [RES_W-1:0] res
);

  logic [1:0]  ph_r, ph_nxt;
  logic        done_r;
  logic [55:0] lo_r, hi_r;
  logic signed [RES_W-1:0] res_r;
  logic [ACC_W-1:0] amag;
  logic [31:0] bmag;
  logic        neg;
  logic [79:0] prod;
  logic [63:0] pmag;

  assign amag = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
  assign bmag = b[32] ? 32'(-b) : 32'(b);
  assign neg  = a[ACC_W-1] ^ b[32];
  assign prod = {hi_r, 24'b0} + {24'b0, lo_r};
  assign pmag = prod[79:16];

  always_comb begin
    ph_nxt = ph_r;
    case (ph_r)
      2'd0: if (go) ph_nxt = 2'd1;
      2'd1: ph_nxt = 2'd2;
      2'd2: ph_nxt = 2'd3;
      default: ph_nxt = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= 2'd0;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= (ph_r == 2'd3);
    end
    if (ph_r == 2'd1) lo_r <= amag[23:0] * bmag;
    if (ph_r == 2'd2) hi_r <= amag[47:24] * bmag;
    if (ph_r == 2'd3) res_r <= neg ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

FILE: sv/lpid_div.sv
// Unsigned restoring divider, two quotient bits per cycle, sign applied at end.
// 64-bit numerator, 32-bit divisor, truncation toward zero; uses lpid_pkg.
module lpid_div
  import lpid_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    go,
  input  logic [63:0]             num,
  input  logic                    neg,
  input  logic [31:0]             den,
  output logic                    done,
  output logic signed [RES_W-1:0] res
);

  logic        busy_r, done_r, neg_r;
  logic [4:0]  cnt_r;
  logic [63:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r;

  always_comb begin
    q_nxt   = q_r;
    rem_nxt = rem_r;
    for (int i = 0; i < 2; i++) begin
      rem_nxt = {rem_nxt[31:0], q_nxt[63]};
      q_nxt   = {q_nxt[62:0], 1'b0};
      if (rem_nxt >= {1'b0, den_r}) begin
        rem_nxt  = rem_nxt - {1'b0, den_r};
        q_nxt[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (go) begin
      q_r   <= num;
      rem_r <= 33'd0;
      den_r <= den;
      neg_r <= neg;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign res  = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

endmodule

FILE: sv/lpid_dp.sv
// Datapath: config registers, loop state, operand muxing and write-back.
// Instantiates lpid_mul and lpid_div; uses lpid_pkg.
module lpid_dp
  import lpid_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output stat_t            stat,
  input  logic [IN_W-1:0]  in_tdata,
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [31:0]      cfg_data
);

  logic signed [31:0] kp_r, ki_r, kd_r, kff_r;
  logic [DEC_W-1:0]   idec_r, fdec_r;
  logic [1:0]         mode_r;
  logic               en_r;

  logic signed [31:0]      t_r, e_r, fe_r, last_r, d_r;
  logic [31:0]             dt_r;
  logic signed [ACC_W-1:0] fs_r, acc_r, integ_r;
  sval_t                   tmp_r;
  logic                    sat_r, zs_r;
  logic [OUT_W-1:0]        out_r;

  logic signed [ACC_W-1:0] mul_a;
  logic signed [32:0]      mul_b;
  logic                    mul_done, div_done;
  logic signed [RES_W-1:0] mul_res, div_res;
  logic [63:0]             div_num;
  logic                    div_neg;
  logic [31:0]             div_den;
  logic signed [32:0]      diff;
  logic [32:0]             diff_mag;
  logic [ACC_W-1:0]        acc_mag;
  sval_t                   mr, dr, v, din, dout, aout;
  logic signed [31:0]      t_in, m_in;

  assign t_in     = in_tdata[31:0];
  assign m_in     = in_tdata[63:32];
  assign diff     = 33'(fe_r) - 33'(last_r);
  assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
  assign acc_mag  = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign mr       = {mul_res[RES_W-1], mul_res};
  assign dr       = {div_res[RES_W-1], div_res};

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_num = {31'd0, diff_mag};
    div_num = div_num << 16;
    div_neg = diff[32];
    div_den = dt_r;
    case (cmd.op)
      OP_FK: begin mul_a = fs_r; mul_b = {17'd0, fdec_r}; end
      OP_FE: begin mul_a = fs_r; mul_b = {16'd0, DECAY_ONE - {1'b0, fdec_r}}; end
      OP_AK: begin mul_a = acc_r; mul_b = {17'd0, idec_r}; end
      OP_AI: begin mul_a = ACC_W'(fe_r); mul_b = {1'b0, dt_r}; end
      OP_SI: begin mul_a = integ_r; mul_b = 33'(ki_r); end
      OP_SD: begin mul_a = ACC_W'(d_r); mul_b = 33'(kd_r); end
      OP_PK: begin mul_a = tmp_r[ACC_W-1:0]; mul_b = 33'(kp_r); end
      OP_PF: begin mul_a = ACC_W'(t_r); mul_b = 33'(kff_r); end
      OP_IN: begin
        div_num = {acc_mag, 16'd0};
        div_neg = acc_r[ACC_W-1];
        div_den = {15'd0, DECAY_ONE - {1'b0, idec_r}};
      end
      default: ;
    endcase
  end

  lpid_mul u_mul (
    .clk(clk), .rst_n(rst_n),
    .go(cmd.go && unit_of(cmd.op) == UNIT_MUL),
    .a(mul_a), .b(mul_b), .done(mul_done), .res(mul_res)
  );

  lpid_div u_div (
    .clk(clk), .rst_n(rst_n),
    .go(cmd.go && unit_of(cmd.op) == UNIT_DIV),
    .num(div_num), .neg(div_neg), .den(div_den), .done(div_done), .res(div_res)
  );

  always_comb begin
    v    = sval_t'(t_in) - sval_t'(m_in);
    din  = tmp_r + mr;
    dout = clip(tmp_r, DATA_W);
    aout = clip(sval_t'(acc_r), DATA_W);
    case (cmd.op)
      OP_LOAD: v = sval_t'(t_in) - sval_t'(m_in);
      OP_FK:   v = mr + sval_t'(e_r);
      OP_SI:   v = sval_t'(fe_r) + mr;
      OP_AI:   v = tmp_r + mr;
      default: v = tmp_r + mr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= '0;
      ki_r   <= '0;
      kd_r   <= '0;
      kff_r  <= '0;
      idec_r <= '0;
      fdec_r <= '0;
      mode_r <= '0;
      en_r   <= 1'b1;
      fs_r   <= '0;
      acc_r  <= '0;
      last_r <= '0;
    end else begin
      if (cmd.wb) begin
        case (cmd.op)
          OP_LOAD: begin
            t_r   <= t_in;
            dt_r  <= in_tdata[95:64];
            e_r   <= 32'(clip(v, DATA_W));
            sat_r <= ovf(v, DATA_W);
            zs_r  <= 1'b0;
          end
          OP_FK: begin
            fs_r  <= ACC_W'(clip(v, ACC_W));
            sat_r <= sat_r | ovf(v, ACC_W);
          end
          OP_FE: begin
            fe_r  <= 32'(clip(mr, DATA_W));
            sat_r <= sat_r | ovf(mr, DATA_W);
          end
          OP_NOF: begin
            fs_r <= '0;
            fe_r <= e_r;
          end
          OP_DV: begin
            d_r   <= 32'(clip(dr, DATA_W));
            sat_r <= sat_r | ovf(dr, DATA_W);
          end
          OP_DZ: begin
            d_r  <= '0;
            zs_r <= 1'b1;
          end
          OP_AK: tmp_r <= mr;
          OP_AI: begin
            acc_r <= ACC_W'(clip(v, ACC_W));
            sat_r <= sat_r | ovf(v, ACC_W);
          end
          OP_IN: begin
            integ_r <= ACC_W'(clip(dr, ACC_W));
            sat_r   <= sat_r | ovf(dr, ACC_W);
          end
          OP_SI: tmp_r <= v;
          OP_SD: begin
            tmp_r <= clip(din, ACC_W);
            sat_r <= sat_r | ovf(din, ACC_W);
          end
          OP_PK: tmp_r <= mr;
          OP_PF: tmp_r <= din;
          OP_FIN: begin
            last_r <= fe_r;
            out_r  <= {6'd0, zs_r,
                       sat_r | ovf(tmp_r, DATA_W) | ovf(sval_t'(acc_r), DATA_W),
                       aout[31:0], fe_r, en_r ? dout[31:0] : t_r};
          end
          default: ;
        endcase
      end
      // any valid register write restarts the loop state
      if (cfg_we) begin
        case (cfg_index)
          REG_KP:   kp_r   <= cfg_data;
          REG_KI:   ki_r   <= cfg_data;
          REG_KD:   kd_r   <= cfg_data;
          REG_KFF:  kff_r  <= cfg_data;
          REG_IDEC: idec_r <= cfg_data[DEC_W-1:0];
          REG_FDEC: fdec_r <= cfg_data[DEC_W-1:0];
          REG_MODE: mode_r <= cfg_data[1:0];
          REG_EN:   en_r   <= cfg_data[0];
          default: ;
        endcase
        if (cfg_index <= REG_EN) begin
          fs_r   <= '0;
          acc_r  <= '0;
          last_r <= '0;
        end
      end
    end
  end

  assign stat.mul_done = mul_done;
  assign stat.div_done = div_done;
  assign stat.filt_on  = mode_r[1];
  assign stat.ff_on    = mode_r[0];
  assign stat.dt_zero  = (dt_r == 32'd0);
  assign out_tdata     = out_r;

endmodule

FILE: sv/lpid_ctrl.sv
// Sequencer: walks the per-beat operation list and handles both handshakes.
// Drives cmd_t to lpid_dp and reads its stat_t; uses lpid_pkg.
module lpid_ctrl
  import lpid_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  output logic  out_tvalid,
  input  logic  out_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0] state_r, state_nxt;
  op_t        op_r, op_nxt;
  logic       done;

  function automatic op_t next_op(input op_t op, input stat_t s);
    op_t n;
    case (op)
      OP_LOAD: n = s.filt_on ? OP_FK : OP_NOF;
      OP_FK:   n = OP_FE;
      OP_FE, OP_NOF: n = s.dt_zero ? OP_DZ : OP_DV;
      OP_DV, OP_DZ: n = OP_AK;
      OP_AK:   n = OP_AI;
      OP_AI:   n = OP_IN;
      OP_IN:   n = OP_SI;
      OP_SI:   n = OP_SD;
      OP_SD:   n = OP_PK;
      OP_PK:   n = s.ff_on ? OP_PF : OP_FIN;
      default: n = OP_FIN;
    endcase
    return n;
  endfunction

  always_comb begin
    case (unit_of(op_r))
      UNIT_MUL: done = stat.mul_done;
      UNIT_DIV: done = stat.div_done;
      default:  done = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd.go    = 1'b0;
    cmd.wb    = 1'b0;
    cmd.op    = op_r;
    case (state_r)
      S_IDLE: begin
        cmd.op = OP_LOAD;
        cmd.wb = in_tvalid;
        if (in_tvalid) begin
          op_nxt    = next_op(OP_LOAD, stat);
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.go    = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (done) begin
          cmd.wb    = 1'b1;
          op_nxt    = next_op(op_r, stat);
          state_nxt = (op_r == OP_FIN) ? S_OUT : S_ISSUE;
        end
      end
      default: begin
        if (out_tready) state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_LOAD;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);

endmodule

FILE: sv/leaky_pid_with_ff_filter_core.sv
// Leaky PID with error pre-filter and setpoint feedforward, top level.
// One beat at a time: each input beat runs, in sequence, up to two divide steps
// (two quotient bits a cycle) and five to eight multiply steps to make its result
// beat; filter, step and feedforward pick the ops.
// Next beat is taken the cycle after the result leaves.
// Synchronous active-low reset: gains zero, loop enabled, loop state cleared.
module leaky_pid_with_ff_filter_core
  import lpid_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // target[31:0], measured[63:32], step_time[95:64]
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // drive[31:0], filtered_error[63:32], accum_error[95:64],
  // sat_flag[96], zero_step_flag[97], zero pad above
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [31:0]      cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  lpid_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .stat(stat), .cmd(cmd)
  );

  lpid_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .cmd(cmd), .stat(stat),
    .in_tdata(in_tdata), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

endmodule
